// ===== hdl/pthc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH compensation package
// Shared word types, register codes and 64-bit wrapping arithmetic helpers.
// ----------------------------------------------------------------------------
package pthc_pkg;

	localparam int unsigned DIV_STEPS = 64;
	localparam logic [63:0] HUM_CLAMP = 64'd419430400;
	localparam logic [16:0] HUM_MAX   = 17'd102400;

	typedef enum logic [2:0] {
		REG_TEMP,
		REG_PRESS_LOW,
		REG_PRESS_HIGH,
		REG_PRESS_LAST,
		REG_HUM
	} reg_idx_t;

	// word leaving the temperature section
	typedef struct packed {
		logic signed [31:0] tf;
		logic signed [23:0] temp;
		logic [19:0]        raw_press;
		logic [15:0]        raw_hum;
	} tword_t;

	// word leaving the humidity section
	typedef struct packed {
		logic signed [31:0] tf;
		logic signed [23:0] temp;
		logic [19:0]        raw_press;
		logic [16:0]        hum;
	} hword_t;

	// side data riding along the divider
	typedef struct packed {
		logic signed [23:0] temp;
		logic [16:0]        hum;
		logic               neg;
		logic               zero;
	} dside_t;

	// finished result word
	typedef struct packed {
		logic signed [23:0] temp;
		logic [31:0]        press;
		logic               press_ok;
		logic [16:0]        hum;
	} rword_t;

	// partial products of a 64 x 64 product, low 64 bits only
	typedef struct packed {
		logic [63:0] p0;
		logic [31:0] p1;
	} mpp_t;

	function automatic mpp_t mul_pp(logic [63:0] a, logic [63:0] b);
		mpp_t        r;
		logic [31:0] m1;
		logic [31:0] m2;
		r.p0 = a[31:0] * b[31:0];
		m1   = a[31:0] * b[63:32];
		m2   = a[63:32] * b[31:0];
		r.p1 = m1 + m2;
		return r;
	endfunction

	function automatic logic [63:0] mul_sum(mpp_t x);
		return x.p0 + {x.p1, 32'h0};
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] v, int unsigned n);
		return 64'($signed(v) >>> n);
	endfunction

endpackage

// ===== hdl/pthc_temp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH temperature section
// Five-stage pipeline giving fine temperature and temperature in 0.01 degC.
// ----------------------------------------------------------------------------
module pthc_temp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [47:0]          temp_calib,
	input  logic                 valid_in,
	input  logic [19:0]          raw_temp,
	input  logic [19:0]          raw_press,
	input  logic [15:0]          raw_hum,
	output logic                 valid_out,
	output pthc_pkg::tword_t     word
);

	logic [15:0]        t1;
	logic signed [15:0] t2;
	logic signed [15:0] t3;

	logic [5:1]         vld_s;
	logic signed [18:0] a_s1;
	logic signed [17:0] b_s1;
	logic signed [34:0] at2_s2;
	logic signed [35:0] bb_s2;
	logic signed [23:0] v1_s3;
	logic signed [39:0] bt3_s3;
	logic signed [31:0] tf_s4;
	logic signed [31:0] tf_s5;
	logic signed [23:0] temp_s5;
	logic [19:0]        rp_s [1:5];
	logic [15:0]        rh_s [1:5];

	assign t1 = temp_calib[15:0];
	assign t2 = $signed(temp_calib[31:16]);
	assign t3 = $signed(temp_calib[47:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:1], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= $signed({2'b0, raw_temp[19:3]}) - $signed({2'b0, t1, 1'b0});
			b_s1    <= $signed({2'b0, raw_temp[19:4]}) - $signed({2'b0, t1});
			at2_s2  <= a_s1 * t2;
			bb_s2   <= b_s1 * b_s1;
			v1_s3   <= 24'(at2_s2 >>> 11);
			bt3_s3  <= $signed(bb_s2[35:12]) * t3;
			tf_s4   <= 32'(v1_s3) + 32'(bt3_s3 >>> 14);
			tf_s5   <= tf_s4;
			temp_s5 <= 24'(((36'(tf_s4) <<< 2) + 36'(tf_s4) + 36'sd128) >>> 8);
			rp_s[1] <= raw_press;
			rh_s[1] <= raw_hum;
			for (int k = 2; k <= 5; k++) begin
				rp_s[k] <= rp_s[k-1];
				rh_s[k] <= rh_s[k-1];
			end
		end
	end

	assign valid_out      = vld_s[5];
	assign word.tf        = tf_s5;
	assign word.temp      = temp_s5;
	assign word.raw_press = rp_s[5];
	assign word.raw_hum   = rh_s[5];

endmodule

// ===== hdl/pthc_hum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH humidity section
// Seventeen-stage pipeline for relative humidity in Q22.10, clamped to 100%.
// ----------------------------------------------------------------------------
module pthc_hum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [63:0]          hum_calib,
	input  logic                 valid_in,
	input  pthc_pkg::tword_t     word_in,
	output logic                 valid_out,
	output pthc_pkg::hword_t     word_out
);

	localparam int unsigned HS = 17;

	logic [63:0] h1, h2, h3, h4, h5, h6;

	logic [HS:1]        vld_s;
	pthc_pkg::tword_t   side_s [1:HS];

	logic [63:0]    x_s1, a0_s1, a0_s2, a0_s3;
	pthc_pkg::mpp_t ppa_s2, ppb_s2, ppc_s2;
	logic [63:0]    h5x_s3, xh6_s3, xh3_s3;
	logic [63:0]    y_s4, za_s4, zb_s4;
	pthc_pkg::mpp_t ppz_s5;
	logic [63:0]    y_s5, z1_s6, y_s6, zc_s7, y_s7;
	pthc_pkg::mpp_t pph_s8;
	logic [63:0]    y_s8, z2_s9, y_s9;
	pthc_pkg::mpp_t ppy_s10;
	logic [63:0]    x2_s11;
	pthc_pkg::mpp_t ppq_s12;
	logic [63:0]    x2_s12, yy_s13, x2_s13;
	pthc_pkg::mpp_t ppr_s14;
	logic [63:0]    x2_s14, t_s15, x2_s15, x3_s16;
	logic [16:0]    hum_s17;

	assign h1 = 64'(hum_calib[7:0]);
	assign h2 = 64'($signed(hum_calib[23:8]));
	assign h3 = 64'(hum_calib[31:24]);
	assign h4 = 64'($signed(hum_calib[43:32]));
	assign h5 = 64'($signed(hum_calib[55:44]));
	assign h6 = 64'($signed(hum_calib[63:56]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[HS-1:1], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= word_in;
			for (int k = 2; k <= HS; k++) begin
				side_s[k] <= side_s[k-1];
			end
			x_s1    <= 64'($signed(word_in.tf)) - 64'd76800;
			a0_s1   <= ({48'h0, word_in.raw_hum} << 14) - (h4 << 20) + 64'd16384;
			ppa_s2  <= pthc_pkg::mul_pp(h5, x_s1);
			ppb_s2  <= pthc_pkg::mul_pp(x_s1, h6);
			ppc_s2  <= pthc_pkg::mul_pp(x_s1, h3);
			a0_s2   <= a0_s1;
			h5x_s3  <= pthc_pkg::mul_sum(ppa_s2);
			xh6_s3  <= pthc_pkg::mul_sum(ppb_s2);
			xh3_s3  <= pthc_pkg::mul_sum(ppc_s2);
			a0_s3   <= a0_s2;
			y_s4    <= pthc_pkg::asr64(a0_s3 - h5x_s3, 15);
			za_s4   <= pthc_pkg::asr64(xh6_s3, 10);
			zb_s4   <= pthc_pkg::asr64(xh3_s3, 11) + 64'd32768;
			ppz_s5  <= pthc_pkg::mul_pp(za_s4, zb_s4);
			y_s5    <= y_s4;
			z1_s6   <= pthc_pkg::mul_sum(ppz_s5);
			y_s6    <= y_s5;
			zc_s7   <= pthc_pkg::asr64(z1_s6, 10) + 64'd2097152;
			y_s7    <= y_s6;
			pph_s8  <= pthc_pkg::mul_pp(zc_s7, h2);
			y_s8    <= y_s7;
			z2_s9   <= pthc_pkg::mul_sum(pph_s8) + 64'd8192;
			y_s9    <= y_s8;
			ppy_s10 <= pthc_pkg::mul_pp(y_s9, pthc_pkg::asr64(z2_s9, 14));
			x2_s11  <= pthc_pkg::mul_sum(ppy_s10);
			ppq_s12 <= pthc_pkg::mul_pp(pthc_pkg::asr64(x2_s11, 15),
				pthc_pkg::asr64(x2_s11, 15));
			x2_s12  <= x2_s11;
			yy_s13  <= pthc_pkg::mul_sum(ppq_s12);
			x2_s13  <= x2_s12;
			ppr_s14 <= pthc_pkg::mul_pp(pthc_pkg::asr64(yy_s13, 7), h1);
			x2_s14  <= x2_s13;
			t_s15   <= pthc_pkg::mul_sum(ppr_s14);
			x2_s15  <= x2_s14;
			x3_s16  <= x2_s15 - pthc_pkg::asr64(t_s15, 4);
			if (x3_s16[63]) begin
				hum_s17 <= '0;
			end else if (x3_s16 > pthc_pkg::HUM_CLAMP) begin
				hum_s17 <= pthc_pkg::HUM_MAX;
			end else begin
				hum_s17 <= x3_s16[28:12];
			end
		end
	end

	assign valid_out          = vld_s[HS];
	assign word_out.tf        = side_s[HS].tf;
	assign word_out.temp      = side_s[HS].temp;
	assign word_out.raw_press = side_s[HS].raw_press;
	assign word_out.hum       = hum_s17;

endmodule

// ===== hdl/pthc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH divider
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module pthc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic [63:0]          dvd,
	input  logic [31:0]          dvs,
	input  pthc_pkg::dside_t     side_in,
	output logic                 valid_out,
	output logic [63:0]          quo,
	output pthc_pkg::dside_t     side_out
);

	localparam int unsigned N = pthc_pkg::DIV_STEPS;

	logic [N-1:0]     vld_s;
	logic [31:0]      rem_s  [0:N-1];
	logic [63:0]      dq_s   [0:N-1];
	logic [31:0]      dvs_s  [0:N-1];
	pthc_pkg::dside_t side_s [0:N-1];

	logic [31:0]      rem_n  [0:N-1];
	logic [63:0]      dq_n   [0:N-1];

	always_comb begin
		logic [31:0] rc;
		logic [63:0] dc;
		logic [31:0] sc;
		logic [32:0] trial;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				rc = '0;
				dc = dvd;
				sc = dvs;
			end else begin
				rc = rem_s[k-1];
				dc = dq_s[k-1];
				sc = dvs_s[k-1];
			end
			trial = {rc, dc[63]};
			if (trial >= {1'b0, sc}) begin
				rem_n[k] = 32'(trial - {1'b0, sc});
				dq_n[k]  = {dc[62:0], 1'b1};
			end else begin
				rem_n[k] = trial[31:0];
				dq_n[k]  = {dc[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s[0]  <= dvs;
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				dvs_s[k]  <= dvs_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_n[k];
				dq_s[k]  <= dq_n[k];
			end
		end
	end

	assign valid_out = vld_s[N-1];
	assign quo       = dq_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

// ===== hdl/pthc_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH pressure section
// Coefficient products, pipelined 64-bit division and final correction.
// ----------------------------------------------------------------------------
module pthc_press (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [63:0]          press_calib_low,
	input  logic [63:0]          press_calib_high,
	input  logic [15:0]          press_calib_last,
	input  logic                 valid_in,
	input  pthc_pkg::hword_t     word_in,
	output logic                 valid_out,
	output pthc_pkg::rword_t     word_out
);

	localparam int unsigned PRE = 11;

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	logic [PRE:1]     vld_s;
	pthc_pkg::hword_t side_s [1:PRE];

	logic [63:0]    d_s1, np_s1, np_s2, np_s3, np_s4, np_s5, np_s6, np_s7;
	pthc_pkg::mpp_t ppdd_s2, ppd5_s2, ppd2_s2;
	logic [63:0]    dd_s3, d5_s3, d2_s3;
	pthc_pkg::mpp_t ppd6_s4, ppd3_s4;
	logic [63:0]    d5_s4, d2_s4, dd6_s5, dd3_s5, d5_s5, d2_s5;
	logic [63:0]    v2a_s6, u1_s6, v2_s7, w_s7;
	pthc_pkg::mpp_t ppw_s8;
	logic [63:0]    num0_s8, dv_s9;
	pthc_pkg::mpp_t ppn_s9;
	logic [63:0]    num_s10, dv_s10;
	logic [63:0]    dvd_s11;
	logic [31:0]    dvs_s11;
	logic           neg_s11, zero_s11;

	logic             dq_valid;
	logic [63:0]      quo;
	pthc_pkg::dside_t dq_side;
	pthc_pkg::dside_t dside_in;

	logic [19:12]     vpost_s;
	pthc_pkg::dside_t post_s [12:19];
	logic [63:0]      p_s12, p_s13, p_s14, p_s15, p_s16;
	pthc_pkg::mpp_t   ppx_s13, pp8_s13, ppx9_s15;
	logic [63:0]      xx_s14, p8p_s14, p8p_s15, p8p_s16, xx9_s16;
	logic [63:0]      s1_s17, p8p_s17, s2_s18;
	logic [31:0]      press_s19;

	assign p1 = 64'(press_calib_low[15:0]);
	assign p2 = 64'($signed(press_calib_low[31:16]));
	assign p3 = 64'($signed(press_calib_low[47:32]));
	assign p4 = 64'($signed(press_calib_low[63:48]));
	assign p5 = 64'($signed(press_calib_high[15:0]));
	assign p6 = 64'($signed(press_calib_high[31:16]));
	assign p7 = 64'($signed(press_calib_high[47:32]));
	assign p8 = 64'($signed(press_calib_high[63:48]));
	assign p9 = 64'($signed(press_calib_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vpost_s <= '0;
		end else if (en) begin
			vld_s   <= {vld_s[PRE-1:1], valid_in};
			vpost_s <= {vpost_s[18:12], dq_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= word_in;
			for (int k = 2; k <= PRE; k++) begin
				side_s[k] <= side_s[k-1];
			end
			d_s1    <= 64'($signed(word_in.tf)) - 64'd128000;
			np_s1   <= 64'(21'h100000 - {1'b0, word_in.raw_press});
			ppdd_s2 <= pthc_pkg::mul_pp(d_s1, d_s1);
			ppd5_s2 <= pthc_pkg::mul_pp(d_s1, p5);
			ppd2_s2 <= pthc_pkg::mul_pp(d_s1, p2);
			np_s2   <= np_s1;
			dd_s3   <= pthc_pkg::mul_sum(ppdd_s2);
			d5_s3   <= pthc_pkg::mul_sum(ppd5_s2);
			d2_s3   <= pthc_pkg::mul_sum(ppd2_s2);
			np_s3   <= np_s2;
			ppd6_s4 <= pthc_pkg::mul_pp(dd_s3, p6);
			ppd3_s4 <= pthc_pkg::mul_pp(dd_s3, p3);
			d5_s4   <= d5_s3;
			d2_s4   <= d2_s3;
			np_s4   <= np_s3;
			dd6_s5  <= pthc_pkg::mul_sum(ppd6_s4);
			dd3_s5  <= pthc_pkg::mul_sum(ppd3_s4);
			d5_s5   <= d5_s4;
			d2_s5   <= d2_s4;
			np_s5   <= np_s4;
			v2a_s6  <= dd6_s5 + (d5_s5 << 17);
			u1_s6   <= pthc_pkg::asr64(dd3_s5, 8) + (d2_s5 << 12);
			np_s6   <= np_s5;
			v2_s7   <= v2a_s6 + (p4 << 35);
			w_s7    <= 64'h0000_8000_0000_0000 + u1_s6;
			np_s7   <= np_s6;
			ppw_s8  <= pthc_pkg::mul_pp(w_s7, p1);
			num0_s8 <= (np_s7 << 31) - v2_s7;
			dv_s9   <= pthc_pkg::asr64(pthc_pkg::mul_sum(ppw_s8), 33);
			ppn_s9  <= pthc_pkg::mul_pp(num0_s8, 64'd3125);
			num_s10 <= pthc_pkg::mul_sum(ppn_s9);
			dv_s10  <= dv_s9;
			dvd_s11 <= num_s10[63] ? 64'h0 - num_s10 : num_s10;
			dvs_s11 <= dv_s10[63] ? 32'(64'h0 - dv_s10) : dv_s10[31:0];
			neg_s11 <= num_s10[63] ^ dv_s10[63];
			zero_s11 <= (dv_s10 == 64'h0);
		end
	end

	assign dside_in.temp = side_s[PRE].temp;
	assign dside_in.hum  = side_s[PRE].hum;
	assign dside_in.neg  = neg_s11;
	assign dside_in.zero = zero_s11;

	pthc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (vld_s[PRE]),
		.dvd       (dvd_s11),
		.dvs       (dvs_s11),
		.side_in   (dside_in),
		.valid_out (dq_valid),
		.quo       (quo),
		.side_out  (dq_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			post_s[12] <= dq_side;
			for (int k = 13; k <= 19; k++) begin
				post_s[k] <= post_s[k-1];
			end
			p_s12    <= dq_side.neg ? 64'h0 - quo : quo;
			ppx_s13  <= pthc_pkg::mul_pp(pthc_pkg::asr64(p_s12, 13),
				pthc_pkg::asr64(p_s12, 13));
			pp8_s13  <= pthc_pkg::mul_pp(p8, p_s12);
			p_s13    <= p_s12;
			xx_s14   <= pthc_pkg::mul_sum(ppx_s13);
			p8p_s14  <= pthc_pkg::mul_sum(pp8_s13);
			p_s14    <= p_s13;
			ppx9_s15 <= pthc_pkg::mul_pp(xx_s14, p9);
			p8p_s15  <= p8p_s14;
			p_s15    <= p_s14;
			xx9_s16  <= pthc_pkg::mul_sum(ppx9_s15);
			p8p_s16  <= p8p_s15;
			p_s16    <= p_s15;
			s1_s17   <= p_s16 + pthc_pkg::asr64(xx9_s16, 25);
			p8p_s17  <= p8p_s16;
			s2_s18   <= s1_s17 + pthc_pkg::asr64(p8p_s17, 19);
			if (post_s[18].zero) begin
				press_s19 <= '0;
			end else begin
				press_s19 <= 32'(pthc_pkg::asr64(s2_s18, 8) + (p7 << 4));
			end
		end
	end

	assign valid_out         = vpost_s[19];
	assign word_out.temp     = post_s[19].temp;
	assign word_out.press    = press_s19;
	assign word_out.press_ok = !post_s[19].zero;
	assign word_out.hum      = post_s[19].hum;

endmodule

// ===== hdl/pth_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH sensor compensation
// Calibrated temperature, pressure and humidity from one raw sensor triple.
//
//   port group     | role          | handshake
//   sample_*, raw_*| input word    | sample_valid / sample_stall
//   result_*, out  | result word   | result_valid / result_stall
//   cfg_*          | coefficients  | cfg_write, no wait
//
// One word enters per cycle while sample_stall is low; a word passes the
// 64-stage one-bit-per-stage divider on its way to the result register.
// Reset clears all valid bits and the coefficient registers to zero.
// A stalled result freezes the whole pipeline; sample_stall then rises.
// Empty slots flow on freely while the result register is free.
// ----------------------------------------------------------------------------
module pth_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	input  logic [15:0]        raw_hum,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [23:0] temp_centi,
	output logic [31:0]        press_q24_8,
	output logic               press_valid,
	output logic [16:0]        hum_q22_10
);

	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_last_q;
	logic [63:0] hum_calib_q;

	logic             en;
	logic             t_valid, h_valid, r_valid;
	pthc_pkg::tword_t t_word;
	pthc_pkg::hword_t h_word;
	pthc_pkg::rword_t r_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_last_q <= '0;
			hum_calib_q  <= '0;
		end else if (cfg_write) begin
			unique case (pthc_pkg::reg_idx_t'(cfg_index))
				pthc_pkg::REG_TEMP:       temp_calib_q <= cfg_data[47:0];
				pthc_pkg::REG_PRESS_LOW:  press_low_q  <= cfg_data;
				pthc_pkg::REG_PRESS_HIGH: press_high_q <= cfg_data;
				pthc_pkg::REG_PRESS_LAST: press_last_q <= cfg_data[15:0];
				pthc_pkg::REG_HUM:        hum_calib_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance unless a finished word is held at the output
	assign en           = !r_valid || !result_stall;
	assign sample_stall = !en;

	pthc_temp u_temp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.temp_calib (temp_calib_q),
		.valid_in   (sample_valid),
		.raw_temp   (raw_temp),
		.raw_press  (raw_press),
		.raw_hum    (raw_hum),
		.valid_out  (t_valid),
		.word       (t_word)
	);

	pthc_hum u_hum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.hum_calib (hum_calib_q),
		.valid_in  (t_valid),
		.word_in   (t_word),
		.valid_out (h_valid),
		.word_out  (h_word)
	);

	pthc_press u_press (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.press_calib_low  (press_low_q),
		.press_calib_high (press_high_q),
		.press_calib_last (press_last_q),
		.valid_in         (h_valid),
		.word_in          (h_word),
		.valid_out        (r_valid),
		.word_out         (r_word)
	);

	assign result_valid = r_valid;
	assign temp_centi   = r_word.temp;
	assign press_q24_8  = r_word.press;
	assign press_valid  = r_word.press_ok;
	assign hum_q22_10   = r_word.hum;

`ifndef SYNTH
	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !press_valid |-> press_q24_8 == 32'h0)
		else $error("pressure not forced to zero on zero divisor");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> hum_q22_10 <= pthc_pkg::HUM_MAX)
		else $error("humidity above clamp");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled with empty result register");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTH compensation testbench
// Drives raw sensor triples under several coefficient sets and compares each
// result word against an in-bench 64-bit integer compensation predictor,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [23:0] temp;
		logic [31:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} comp_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        sample_valid = 0;
	logic        sample_stall;
	logic [19:0] raw_temp = '0;
	logic [19:0] raw_press = '0;
	logic [15:0] raw_hum = '0;
	logic        result_valid;
	logic        result_stall = 0;
	logic signed [23:0] temp_centi;
	logic [31:0] press_q24_8;
	logic        press_valid;
	logic [16:0] hum_q22_10;

	logic [47:0] c_temp;
	logic [63:0] c_plo, c_phi, c_hum;
	logic [15:0] c_plast;
	comp_t       pending_q[$];
	int          errors = 0;
	int          send_idle = 0;
	int          recv_stall = 0;

	always #6 clk = ~clk;

	pth_sensor_compensation u_top (.*);

	function automatic logic [63:0] sx(logic [63:0] v, int w);
		logic [63:0] m;
		m = (64'd1 << w) - 1;
		v = v & m;
		if (v[w-1])
			v = v | ~m;
		return v;
	endfunction

	function automatic logic [63:0] sra(logic [63:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma, mb, q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] h1, h2, h3, h4, h5, h6;
		logic [63:0] a, b, v1, v2, tf, p, x, y, z;
		comp_t r;
		t1 = c_temp[15:0];
		t2 = sx(c_temp >> 16, 16);
		t3 = sx(c_temp >> 32, 16);
		p1 = c_plo[15:0];
		p2 = sx(c_plo >> 16, 16);
		p3 = sx(c_plo >> 32, 16);
		p4 = sx(c_plo >> 48, 16);
		p5 = sx(c_phi, 16);
		p6 = sx(c_phi >> 16, 16);
		p7 = sx(c_phi >> 32, 16);
		p8 = sx(c_phi >> 48, 16);
		p9 = sx(c_plast, 16);
		h1 = c_hum[7:0];
		h2 = sx(c_hum >> 8, 16);
		h3 = c_hum[31:24];
		h4 = sx(c_hum >> 32, 12);
		h5 = sx(c_hum >> 44, 12);
		h6 = sx(c_hum >> 56, 8);
		a = (64'(rt) >> 3) - (t1 << 1);
		v1 = sra(a * t2, 11);
		b = (64'(rt) >> 4) - t1;
		v2 = sra(sra(b * b, 12) * t3, 14);
		tf = v1 + v2;
		r.temp = 24'(sra(tf * 5 + 128, 8));
		v1 = tf - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sra(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra(((64'd1 << 47) + v1) * p1, 33);
		r.press = '0;
		r.pvalid = 0;
		if (v1 != 0) begin
			p = 64'd1048576 - 64'(rp);
			p = sdiv64(((p << 31) - v2) * 64'd3125, v1);
			x = sra(p, 13);
			v1 = sra(p9 * x * x, 25);
			v2 = sra(p8 * p, 19);
			p = sra(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.pvalid = 1;
		end
		x = tf - 64'd76800;
		y = sra((64'(rh) << 14) - (h4 << 20) - (h5 * x) + 64'd16384, 15);
		z = sra(x * h6, 10) * (sra(x * h3, 11) + 64'd32768);
		z = (sra(z, 10) + 64'd2097152) * h2 + 64'd8192;
		x = y * sra(z, 14);
		y = sra(x, 15);
		x = x - sra(sra(y * y, 7) * h1, 4);
		if (x[63])
			x = '0;
		if (x > pthc_pkg::HUM_CLAMP)
			x = pthc_pkg::HUM_CLAMP;
		r.hum = x[28:12];
		return r;
	endfunction

	task automatic write_reg(pthc_pkg::reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 0;
		case (idx)
			pthc_pkg::REG_TEMP:       c_temp = val[47:0];
			pthc_pkg::REG_PRESS_LOW:  c_plo = val;
			pthc_pkg::REG_PRESS_HIGH: c_phi = val;
			pthc_pkg::REG_PRESS_LAST: c_plast = val[15:0];
			pthc_pkg::REG_HUM:        c_hum = val;
			default: ;
		endcase
	endtask

	task automatic load_calib(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
			logic [15:0] last, logic [63:0] h);
		write_reg(pthc_pkg::REG_TEMP, {16'hdead, t});
		write_reg(pthc_pkg::REG_PRESS_LOW, lo);
		write_reg(pthc_pkg::REG_PRESS_HIGH, hi);
		write_reg(pthc_pkg::REG_PRESS_LAST, {48'hbeef, last});
		write_reg(pthc_pkg::REG_HUM, h);
	endtask

	// send one word; inputs change on the falling edge
	task automatic send_word(logic [19:0] t, logic [19:0] p, logic [15:0] h);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 0;
			@(negedge clk);
		end
		sample_valid <= 1;
		raw_temp <= t;
		raw_press <= p;
		raw_hum <= h;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pending_q.push_back(compensate(t, p, h));
		@(negedge clk);
	endtask

	task automatic drain;
		sample_valid <= 0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		comp_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t unexpected word: temp %h press %h ok %b hum %h", $time,
					temp_centi, press_q24_8, press_valid, hum_q22_10);
			end else begin
				e = pending_q.pop_front();
				if (e.temp !== temp_centi || e.press !== press_q24_8 ||
						e.pvalid !== press_valid || e.hum !== hum_q22_10) begin
					errors++;
					$display("%0t mismatch: exp %h %h %b %h act %h %h %b %h", $time,
						e.temp, e.press, e.pvalid, e.hum,
						temp_centi, press_q24_8, press_valid, hum_q22_10);
				end
			end
		end
	end

	task automatic test_zero_calib;
		send_word('0, '0, '0);
		send_word(20'hfffff, 20'hfffff, 16'hffff);
		send_word(20'h80000, 20'h12345, 16'h8000);
		drain();
	endtask

	task automatic test_typical;
		load_calib({16'hfc18, 16'h6770, 16'h6e3b},
			{16'h1770, 16'hfff9, 16'h0b72, 16'h8e5c} ^ 64'h0 | {16'h1c56, 48'h0} |
			64'h0, 64'h0, 16'h0, 64'h0);
		load_calib({16'hfc18, 16'h6770, 16'h6e3b},
			{16'h1c56, 16'h0bd0, 16'hd6b4, 16'h8f8a},
			{16'h3b8c, 16'hc7b8, 16'hfff9, 16'h003c}, 16'h1770,
			{8'h1e, 12'h000, 12'h143, 8'h00, 16'h016f, 8'h4b});
		send_word(20'h84a8c, 20'h53d0c, 16'h6ec5);
		send_word(20'h7e000, 20'h40000, 16'h0000);
		send_word(20'h90000, 20'h60000, 16'hffff);
		send_word('0, '0, '0);
		send_word(20'hfffff, 20'hfffff, 16'hffff);
		send_word(20'h55555, 20'haaaaa, 16'h5555);
		send_word(20'haaaaa, 20'h55555, 16'haaaa);
		drain();
	endtask

	task automatic test_extremes;
		load_calib('1, '1, '1, 16'h7fff, '1);
		send_word(20'hfffff, '0, 16'hffff);
		send_word('0, 20'hfffff, '0);
		drain();
		load_calib({16'h8000, 16'h8000, 16'hffff}, {16'h8000, 16'h8000, 16'h8000, 16'hffff},
			{4{16'h8000}}, 16'h8000, {8'h80, 12'h800, 12'h800, 8'hff, 16'h8000, 8'hff});
		send_word(20'hfffff, 20'hfffff, 16'hffff);
		send_word('0, '0, '0);
		send_word(20'h7ffff, 20'h80000, 16'h7fff);
		drain();
		// P1 zero forces the divisor to zero
		load_calib({16'hfc18, 16'h6770, 16'h6e3b}, 64'h1234_5678_9abc_0000,
			64'h1111_2222_3333_4444, 16'h0123, 64'h4b00_1430_0016_f1e);
		send_word(20'h84a8c, 20'h53d0c, 16'h6ec5);
		drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		int k;
		send_idle = idle;
		recv_stall = stall;
		if ($urandom_range(1))
			load_calib({16'hfc18 ^ 16'($urandom_range(255)), 16'h6770, 16'h6e3b},
				{16'h1c56, 16'h0bd0, 16'hd6b4, 16'h8f8a ^ 16'($urandom_range(4095))},
				{16'h3b8c, 16'hc7b8, 16'hfff9, 16'h003c}, 16'h1770,
				{8'h1e, 12'h000, 12'h143, 8'h00, 16'h016f, 8'h4b});
		else
			load_calib(48'({$urandom, $urandom}), {$urandom, $urandom},
				{$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
		for (k = 0; k < n; k++)
			if ($urandom_range(3) == 0)
				send_word(20'($urandom), 20'($urandom), 16'($urandom));
			else
				send_word(20'($urandom_range(20'h9ffff, 20'h60000)),
					20'($urandom_range(20'h70000, 20'h30000)), 16'($urandom_range(40000, 15000)));
		drain();
	endtask

	initial begin
		c_temp = '0;
		c_plo = '0;
		c_phi = '0;
		c_plast = '0;
		c_hum = '0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		test_zero_calib();
		test_typical();
		test_extremes();
		test_random(60, 0, 0);
		test_random(60, 0, 0);
		test_random(60, 61, 0);
		test_random(60, 61, 0);
		test_random(60, 0, 61);
		test_random(60, 0, 61);
		test_random(60, 21, 21);
		recv_stall = 0;
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pthc_pkg.sv
hdl/pthc_temp.sv
hdl/pthc_hum.sv
hdl/pthc_div.sv
hdl/pthc_press.sv
hdl/pth_sensor_compensation.sv
tb/sv/tb_top.sv
